@@ hw/rtl/wbss_pkg.sv @@
// Shared types, constants and helpers for the wildcard byte signature scanner.
`default_nettype none

package wbss_pkg;

  // Scanner geometry
  localparam int PATTERN_MAX   = 16;
  localparam int ADDRESS_WIDTH = 32;
  localparam int WIN_DEPTH     = (PATTERN_MAX < 3) ? 3 : PATTERN_MAX;
  localparam int FILL_W        = $clog2(WIN_DEPTH + 1);
  localparam int WIN_IDX_W     = $clog2(WIN_DEPTH);
  localparam int SEL_W         = (FILL_W > 4) ? FILL_W : 4;

  // Result address is cut to the configured address width, then to 32 bits
  localparam logic [31:0] ADDR_MASK =
    (ADDRESS_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDRESS_WIDTH) - 64'd1);

  // Configuration register indexes
  localparam logic [2:0] CFG_SCAN_BASE      = 3'd0;
  localparam logic [2:0] CFG_PATTERN_LOW    = 3'd1;
  localparam logic [2:0] CFG_PATTERN_HIGH   = 3'd2;
  localparam logic [2:0] CFG_CARE_MASK      = 3'd3;
  localparam logic [2:0] CFG_PATTERN_LENGTH = 3'd4;
  localparam logic [2:0] CFG_BACKTRACE      = 3'd5;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND       = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND   = 2'd1;
  localparam logic [1:0] STATUS_NO_PROLOGUE = 2'd2;

  // Function prologue bytes: push ebp; mov ebp, esp
  localparam logic [7:0] PROLOGUE_B0 = 8'h55;
  localparam logic [7:0] PROLOGUE_B1 = 8'h8B;
  localparam logic [7:0] PROLOGUE_B2 = 8'hEC;

  // Per-cell compare setup
  typedef struct packed {
    logic       care;
    logic [7:0] pat;
  } wbss_cell_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } wbss_result_t;

  // Clamp the programmed length into 1..PATTERN_MAX
  function automatic logic [FILL_W-1:0] eff_length(input logic [4:0] len);
    logic [FILL_W-1:0] res;
    if (len == 5'd0) begin
      res = FILL_W'(1);
    end else if (32'(len) > 32'(PATTERN_MAX)) begin
      res = FILL_W'(PATTERN_MAX);
    end else begin
      res = FILL_W'(len);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wildcard_byte_signature_scan_unit.sv @@
// Top level of the wildcard byte signature scanner: cell chain, scan control, result stage.
// Throughput: one byte item per cycle, back to back, unless the result skid entry is full;
//   set by the combinational parallel compare across the cell chain.
// Result: a result item is registered in the output stage (or its skid entry when the
//   master side stalls) when the byte item that completes the match (or ends the region) is accepted.
// Reset: asynchronous, active low; control registers return to reset values (byte and result
//   data registers are not reset) and the scan starts as if a new region began. No clearing pass is needed.
`default_nettype none

module wildcard_byte_signature_scan_unit
  import wbss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  // Byte stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] region_first
  input  logic        s_axis_tlast_i,   // region_last
  // Result out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [1:0] scan_status, [33:2] result_address, zero pad
);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [31:0] scan_base_q;
  logic [63:0] pattern_low_q;
  logic [63:0] pattern_high_q;
  logic [15:0] care_mask_q;
  logic [4:0]  pattern_length_q;
  logic        backtrace_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_base_q      <= '0;
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      care_mask_q      <= '0;
      pattern_length_q <= 5'd1;
      backtrace_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCAN_BASE:      scan_base_q      <= cfg_data_i[31:0];
        CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data_i;
        CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data_i;
        CFG_CARE_MASK:      care_mask_q      <= cfg_data_i[15:0];
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[4:0];
        CFG_BACKTRACE:      backtrace_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [FILL_W-1:0] eff_len;
  logic [127:0]      pattern_all;

  assign eff_len     = eff_length(pattern_length_q);
  assign pattern_all = {pattern_high_q, pattern_low_q};

  // ------------------------------------------------------------------
  // Scan control state
  // ------------------------------------------------------------------
  logic [FILL_W-1:0] fill_q, fill_d, fill_c;
  logic [31:0]       pos_q, pos_d;
  logic              older_valid_q, older_valid_d;
  logic [31:0]       older_off_q, older_off_d;
  logic              done_q, done_d;

  logic in_accept, take, first;
  logic buf_ready;

  assign s_axis_tready_o = buf_ready;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign first           = s_axis_tuser_i;
  // Drop bytes after a result until the next region starts
  assign take            = in_accept && (first || !done_q);

  // Fill count as seen after an optional region restart
  assign fill_c = first ? '0 : fill_q;
  assign fill_d = (32'(fill_c) < WIN_DEPTH) ? fill_c + 1'b1 : fill_c;
  assign pos_d  = first ? '0 : ((fill_q == '0) ? '0 : pos_q + 32'd1);

  // ------------------------------------------------------------------
  // Cell chain: byte window shifts one cell per scanned item
  // ------------------------------------------------------------------
  logic [7:0]     cell_byte  [WIN_DEPTH];
  logic [7:0]     cell_byte_in [WIN_DEPTH];
  logic           cell_mark  [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] mark_in;
  logic [WIN_DEPTH-1:0] cell_hit;
  wbss_cell_cfg_t cell_cfg   [WIN_DEPTH];
  logic           new_mark;

  // Prologue ends at the new byte: 55 8B EC in address order
  assign new_mark = (32'(fill_c) >= 2) && (s_axis_tdata_i == PROLOGUE_B2) &&
                    (cell_byte[0] == PROLOGUE_B1) && (cell_byte[1] == PROLOGUE_B0);

  assign cell_byte_in[0] = s_axis_tdata_i;
  assign mark_in[0]      = new_mark;

  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    logic [SEL_W-1:0] sel;
    logic             in_use;

    if (k > 0) begin : g_link
      assign cell_byte_in[k] = cell_byte[k-1];
      // Marks of an earlier region must not survive a restart
      assign mark_in[k]      = first ? 1'b0 : cell_mark[k-1];
    end

    // Cell k holds the byte that pattern position (len-1-k) lines up with
    assign in_use = (32'(k) < 32'(eff_len));
    assign sel    = SEL_W'(eff_len) - SEL_W'(k) - SEL_W'(1);

    always_comb begin
      cell_cfg[k].care = in_use && (32'(sel) < 32'd16) && care_mask_q[sel[3:0]];
      cell_cfg[k].pat  = pattern_all[8*sel[3:0] +: 8];
    end

    wbss_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (take),
      .byte_i (cell_byte_in[k]),
      .mark_i (mark_in[k]),
      .cfg_i  (cell_cfg[k]),
      .byte_o (cell_byte[k]),
      .mark_o (cell_mark[k]),
      .hit_o  (cell_hit[k])
    );
  end

  // ------------------------------------------------------------------
  // Match, backtrace and result
  // ------------------------------------------------------------------
  logic                 match;
  logic                 bt_found;
  logic [WIN_IDX_W-1:0] bt_idx;
  logic                 push;
  wbss_result_t         res;
  logic [31:0]          match_start;
  logic [31:0]          bt_off;

  assign match = (fill_d >= eff_len) && (&cell_hit);

  // Nearest prologue whose last byte sits at or before the match start
  always_comb begin
    bt_found = 1'b0;
    bt_idx   = '0;
    for (int a = WIN_DEPTH - 1; a >= 0; a--) begin
      if (mark_in[a] && (FILL_W'(a + 1) >= eff_len)) begin
        bt_found = 1'b1;
        bt_idx   = WIN_IDX_W'(a);
      end
    end
  end

  assign match_start = pos_d - 32'(eff_len) + 32'd1;
  assign bt_off      = pos_d - 32'(bt_idx) - 32'd2;

  always_comb begin
    res.status = STATUS_FOUND;
    res.addr   = (scan_base_q + match_start) & ADDR_MASK;
    if (match) begin
      if (backtrace_q) begin
        if (bt_found) begin
          res.addr = (scan_base_q + bt_off) & ADDR_MASK;
        end else if (older_valid_d) begin
          res.addr = (scan_base_q + older_off_d) & ADDR_MASK;
        end else begin
          res.status = STATUS_NO_PROLOGUE;
          res.addr   = '0;
        end
      end
    end else begin
      res.status = STATUS_NOT_FOUND;
      res.addr   = '0;
    end
  end

  assign push = take && (match || s_axis_tlast_i);

  // Track the latest prologue that has left the window
  always_comb begin
    older_valid_d = first ? 1'b0 : older_valid_q;
    older_off_d   = first ? '0 : older_off_q;
    if ((32'(fill_c) >= WIN_DEPTH) && cell_mark[WIN_DEPTH-1]) begin
      older_valid_d = 1'b1;
      older_off_d   = pos_d - 32'(WIN_DEPTH) - 32'd2;
    end
  end

  assign done_d = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= '0;
      pos_q         <= '0;
      older_valid_q <= 1'b0;
      older_off_q   <= '0;
      done_q        <= 1'b0;
    end else if (take) begin
      fill_q        <= fill_d;
      pos_q         <= pos_d;
      older_valid_q <= older_valid_d;
      older_off_q   <= older_off_d;
      done_q        <= done_d;
    end
  end

  // ------------------------------------------------------------------
  // Result stage
  // ------------------------------------------------------------------
  wbss_result_t out_res;

  wbss_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {6'b0, out_res.addr, out_res.status};

`ifndef SYNTH
  // No result after a finished scan unless a new region starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && done_q) |-> first)
    else $error("result produced after scan completed");

  // A result always closes the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> done_q)
    else $error("scan not closed after result");

  // Only a found result carries an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.status != STATUS_FOUND) |-> (res.addr == '0))
    else $error("address set on a non-found result");

  // Window fill never runs past the chain length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= WIN_DEPTH)
    else $error("window fill overflow");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/wbss_cell.sv @@
// One window cell: holds a byte and its prologue mark, compares the incoming byte.
`default_nettype none

module wbss_cell
  import wbss_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [7:0]     byte_i,
  input  logic           mark_i,
  input  wbss_cell_cfg_t cfg_i,
  output logic [7:0]     byte_o,
  output logic           mark_o,
  output logic           hit_o
);

  logic [7:0] byte_q;
  logic       mark_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else if (en_i) begin
      mark_q <= mark_i;
    end
  end

  // Wildcard positions always hit
  assign hit_o  = !cfg_i.care || (byte_i == cfg_i.pat);
  assign byte_o = byte_q;
  assign mark_o = mark_q;

endmodule

`default_nettype wire

@@ hw/rtl/wbss_out_buf.sv @@
// Two-entry output stage (output register plus skid) for result items.
`default_nettype none

module wbss_out_buf
  import wbss_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  wbss_result_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         pop_ready_i,
  output wbss_result_t data_o
);

  logic         out_valid_q, out_valid_d;
  logic         skd_valid_q, skd_valid_d;
  wbss_result_t out_q, out_d;
  wbss_result_t skd_q, skd_d;
  logic         slot_free;

  assign slot_free = !out_valid_q || pop_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    skd_valid_d = skd_valid_q;
    out_d       = out_q;
    skd_d       = skd_q;
    if (slot_free) begin
      if (skd_valid_q) begin
        // Advance the skid entry; input is stalled while skid is full
        out_d       = skd_q;
        out_valid_d = 1'b1;
        skd_valid_d = 1'b0;
      end else begin
        out_d       = data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skd_d       = data_i;
      skd_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skd_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skd_valid_q <= skd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skd_q <= skd_d;
  end

  assign ready_o = !skd_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire
